@@ rtl/sfd_pkg.sv @@
// shared types and constants for the stereo feedback delay
package sfd_pkg;

	// fixed field widths
	localparam int GAIN_BITS      = 16;
	localparam int DELAY_BITS     = 17;
	localparam int CFG_INDEX_BITS = 2;

	// q0.16 unity and rounding offset
	localparam logic [GAIN_BITS:0] UNITY_GAIN = 17'h10000;
	localparam int                 ROUND_HALF = 32768;

	// configuration register indexes
	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_FEEDBACK_GAIN = 2'd0,
		REG_MIX_GAIN      = 2'd1,
		REG_DELAY_LEFT    = 2'd2,
		REG_DELAY_RIGHT   = 2'd3
	} cfg_reg_t;

	// pipeline control from the top level to each channel
	typedef struct packed {
		logic adv;        // whole pipeline moves one stage
		logic fill_done;  // write position has wrapped at least once
		logic v_s2;       // transaction present in stage 2
		logic v_s3;       // stage 3 write-back register holds a real write
	} sfd_ctrl_t;

endpackage

@@ rtl/sfd_channel.sv @@
// one channel of the echo: history memory, read with forwarding, mix and write-back
module sfd_channel #(
	parameter int HISTORY_DEPTH = 131072,
	parameter int SAMPLE_BITS   = 16
) (
	input  logic                                   clk,
	input  sfd_pkg::sfd_ctrl_t                     ctrl,
	input  logic [sfd_pkg::DELAY_BITS-1:0]         delay,
	input  logic [sfd_pkg::GAIN_BITS-1:0]          feedback_gain,
	input  logic [sfd_pkg::GAIN_BITS-1:0]          mix_gain,
	input  logic [$clog2(HISTORY_DEPTH)-1:0]       wr_pos,
	input  logic signed [SAMPLE_BITS-1:0]          sample_in,
	output logic signed [SAMPLE_BITS-1:0]          sample_out
);

	localparam int AW = $clog2(HISTORY_DEPTH);
	localparam int DB = sfd_pkg::DELAY_BITS;
	localparam int CW = (AW + 1 > DB) ? AW + 1 : DB;
	localparam int GW = sfd_pkg::GAIN_BITS;
	localparam int SB = SAMPLE_BITS;
	localparam int PW = SB + GW + 2;  // sample times 18-bit signed gain
	localparam int FW = SB + GW + 1;  // sample times 17-bit signed gain
	localparam int RW = SB + 3;       // rounded sums before saturation
	localparam logic [CW-1:0] DEPTH_C = CW'(HISTORY_DEPTH);

	// saturate to the signed sample range
	function automatic logic [SB-1:0] sat_sample(input logic [RW-1:0] v);
		logic [SB-1:0] r;
		if (v[RW-1:SB-1] == '0 || v[RW-1:SB-1] == '1) begin
			r = v[SB-1:0];
		end else if (v[RW-1]) begin
			r = {1'b1, {(SB-1){1'b0}}};
		end else begin
			r = {1'b0, {(SB-1){1'b1}}};
		end
		return r;
	endfunction

	logic signed [SB-1:0] hist_mem [HISTORY_DEPTH];

	logic [CW-1:0]        dly_ext;
	logic [CW-1:0]        dly_eff;
	logic [CW-1:0]        pos_ext;
	logic [AW-1:0]        rd_addr;
	logic                 rd_zero;

	logic signed [SB-1:0] rd_data_s1;
	logic [AW-1:0]        rd_addr_s1;
	logic                 rd_zero_s1;
	logic signed [SB-1:0] x_s1;
	logic [AW-1:0]        wp_s1;
	logic signed [SB-1:0] y_s1;
	logic [GW:0]          wet_gain;

	logic signed [PW-1:0] p_wet_s2;
	logic signed [FW-1:0] p_mix_s2;
	logic signed [FW-1:0] p_fb_s2;
	logic signed [SB-1:0] x_s2;
	logic [AW-1:0]        wp_s2;

	logic [PW:0]          acc_out;
	logic [FW:0]          acc_fb;
	logic [SB+1:0]        rnd_fb;
	logic [RW-1:0]        back_sum;
	logic signed [SB-1:0] back_s2;
	logic signed [SB-1:0] mix_s2;

	logic [AW-1:0]        wb_addr_s3;
	logic signed [SB-1:0] wb_data_s3;
	logic signed [SB-1:0] out_q;

	// effective delay and read address; unwritten slots read as zero
	always_comb begin
		dly_ext = CW'(delay);
		if (dly_ext == '0) begin
			dly_eff = CW'(1);
		end else if (dly_ext > DEPTH_C) begin
			dly_eff = DEPTH_C;
		end else begin
			dly_eff = dly_ext;
		end
		pos_ext = CW'(wr_pos);
		if (pos_ext >= dly_eff) begin
			rd_addr = AW'(pos_ext - dly_eff);
		end else begin
			rd_addr = AW'(pos_ext + DEPTH_C - dly_eff);
		end
		rd_zero = !ctrl.fill_done && (dly_eff > pos_ext);
	end

	// history memory: one write and one registered read per advance
	always_ff @(posedge clk) begin
		if (ctrl.adv) begin
			if (ctrl.v_s2) begin
				hist_mem[wp_s2] <= back_s2;
			end
			rd_data_s1 <= hist_mem[rd_addr];
		end
	end

	// stage 1 registers
	always_ff @(posedge clk) begin
		if (ctrl.adv) begin
			rd_addr_s1 <= rd_addr;
			rd_zero_s1 <= rd_zero;
			x_s1       <= sample_in;
			wp_s1      <= wr_pos;
		end
	end

	// delayed sample with forwarding of the two writes the read missed
	always_comb begin
		if (ctrl.v_s2 && wp_s2 == rd_addr_s1) begin
			y_s1 = back_s2;
		end else if (ctrl.v_s3 && wb_addr_s3 == rd_addr_s1) begin
			y_s1 = wb_data_s3;
		end else if (rd_zero_s1) begin
			y_s1 = '0;
		end else begin
			y_s1 = rd_data_s1;
		end
	end

	assign wet_gain = sfd_pkg::UNITY_GAIN - {1'b0, mix_gain};

	// stage 2 registers: products
	always_ff @(posedge clk) begin
		if (ctrl.adv) begin
			p_wet_s2 <= y_s1 * $signed({1'b0, wet_gain});
			p_mix_s2 <= x_s1 * $signed({1'b0, mix_gain});
			p_fb_s2  <= y_s1 * $signed({1'b0, feedback_gain});
			x_s2     <= x_s1;
			wp_s2    <= wp_s1;
		end
	end

	// rounding and saturation of the mix and the feedback sum
	always_comb begin
		acc_out  = {p_wet_s2[PW-1], p_wet_s2} + {{2{p_mix_s2[FW-1]}}, p_mix_s2}
			+ (PW+1)'(sfd_pkg::ROUND_HALF);
		acc_fb   = {p_fb_s2[FW-1], p_fb_s2} + (FW+1)'(sfd_pkg::ROUND_HALF);
		rnd_fb   = acc_fb[FW:GW];
		back_sum = {{3{x_s2[SB-1]}}, x_s2} + {rnd_fb[SB+1], rnd_fb};
		back_s2  = sat_sample(back_sum);
		mix_s2   = sat_sample(acc_out[PW:GW]);
	end

	// stage 3: last write kept for forwarding, and the output sample
	always_ff @(posedge clk) begin
		if (ctrl.adv) begin
			wb_addr_s3 <= wp_s2;
			wb_data_s3 <= back_s2;
			if (ctrl.v_s2) begin
				out_q <= mix_s2;
			end
		end
	end

	assign sample_out = out_q;

endmodule

@@ rtl/stereo_feedback_delay.sv @@
// top level of the stereo feedback delay: registers, pipeline control, two channels
//
// Usage:
//   Input channel in_valid/in_ready carries one stereo frame (in_left, in_right)
//   per transaction; output channel out_valid/out_ready returns one blended
//   frame (out_left, out_right) per input transaction, in order.
//   Configuration is a plain write port (cfg_wen, cfg_index, cfg_wdata):
//   index 0 feedback gain, 1 mix gain, 2 left delay, 3 right delay.
//   Write it only while no transaction is in flight.
// Pipeline and throughput:
//   One frame per cycle while the output register is free or being taken. A
//   frame passes a read stage, a multiply stage and the output register.
//   The rate is set by the single read and single write port of each
//   channel's history memory, used once per frame.
// Reset:
//   Registers return to their defaults and the write position to zero. The
//   memories are not swept: slots not yet written since reset read as zero,
//   tracked by the write position and a wrap flag, so frames are taken at once.
// Stall:
//   When the output register holds an untaken frame, the whole pipeline
//   freezes and in_ready drops until out_ready is seen.
module stereo_feedback_delay #(
	parameter int HISTORY_DEPTH = 131072,
	parameter int SAMPLE_BITS   = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wen,
	input  logic [sfd_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  logic [sfd_pkg::DELAY_BITS-1:0]        cfg_wdata,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [SAMPLE_BITS-1:0]         in_left,
	input  logic signed [SAMPLE_BITS-1:0]         in_right,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [SAMPLE_BITS-1:0]         out_left,
	output logic signed [SAMPLE_BITS-1:0]         out_right
);

	localparam int AW = $clog2(HISTORY_DEPTH);
	localparam int GW = sfd_pkg::GAIN_BITS;
	localparam int DB = sfd_pkg::DELAY_BITS;

	logic [GW-1:0]      feedback_gain_q;
	logic [GW-1:0]      mix_gain_q;
	logic [DB-1:0]      delay_left_q;
	logic [DB-1:0]      delay_right_q;
	logic [AW-1:0]      wr_pos_q;
	logic               fill_done_q;
	logic               v_s1;
	logic               v_s2;
	logic               v_s3;
	logic               out_valid_q;
	logic               adv;
	logic               accept;
	sfd_pkg::sfd_ctrl_t ctrl;

	// pipeline moves whenever the output register is free or being taken
	assign adv      = !out_valid_q || out_ready;
	assign accept   = in_valid && adv;
	assign in_ready = adv;
	assign out_valid = out_valid_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feedback_gain_q <= GW'(32768);
			mix_gain_q      <= GW'(32768);
			delay_left_q    <= DB'(24000);
			delay_right_q   <= DB'(24000);
		end else if (cfg_wen) begin
			case (sfd_pkg::cfg_reg_t'(cfg_index))
				sfd_pkg::REG_FEEDBACK_GAIN: feedback_gain_q <= cfg_wdata[GW-1:0];
				sfd_pkg::REG_MIX_GAIN:      mix_gain_q      <= cfg_wdata[GW-1:0];
				sfd_pkg::REG_DELAY_LEFT:    delay_left_q    <= cfg_wdata;
				sfd_pkg::REG_DELAY_RIGHT:   delay_right_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// write position, wrap flag and stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_pos_q    <= '0;
			fill_done_q <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= accept;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s2;
			if (accept) begin
				if (wr_pos_q == AW'(HISTORY_DEPTH - 1)) begin
					wr_pos_q    <= '0;
					fill_done_q <= 1'b1;
				end else begin
					wr_pos_q <= wr_pos_q + AW'(1);
				end
			end
		end
	end

	assign ctrl = '{adv: adv, fill_done: fill_done_q, v_s2: v_s2, v_s3: v_s3};

	// left channel
	sfd_channel #(
		.HISTORY_DEPTH(HISTORY_DEPTH),
		.SAMPLE_BITS  (SAMPLE_BITS)
	) u_left (
		.clk          (clk),
		.ctrl         (ctrl),
		.delay        (delay_left_q),
		.feedback_gain(feedback_gain_q),
		.mix_gain     (mix_gain_q),
		.wr_pos       (wr_pos_q),
		.sample_in    (in_left),
		.sample_out   (out_left)
	);

	// right channel
	sfd_channel #(
		.HISTORY_DEPTH(HISTORY_DEPTH),
		.SAMPLE_BITS  (SAMPLE_BITS)
	) u_right (
		.clk          (clk),
		.ctrl         (ctrl),
		.delay        (delay_right_q),
		.feedback_gain(feedback_gain_q),
		.mix_gain     (mix_gain_q),
		.wr_pos       (wr_pos_q),
		.sample_in    (in_right),
		.sample_out   (out_right)
	);

endmodule

@@ test/tb_stereo_feedback_delay.sv @@
// self-checking testbench for the stereo feedback delay with a built-in echo predictor
module tb_stereo_feedback_delay;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HIST_DEPTH  = 131072;
	localparam int SAMPLE_W    = 16;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int RAND_PHASES = 9;
	localparam int PLAN_ROWS   = 24;
	localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
	localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left;
		logic signed [SAMPLE_W-1:0] right;
	} frame_t;

	typedef enum logic {ROW_FRAME, ROW_CFG} row_kind_t;
	typedef enum logic [1:0] {RX_OPEN, RX_BURSTY, RX_SPARSE} rx_mode_t;

	typedef struct packed {
		row_kind_t                          kind;
		sfd_pkg::cfg_reg_t                  reg_idx;
		logic [sfd_pkg::DELAY_BITS-1:0]     value;
		logic signed [SAMPLE_W-1:0]         stim_l;
		logic signed [SAMPLE_W-1:0]         stim_r;
		logic                               typed;
		logic signed [SAMPLE_W-1:0]         want_l;
		logic signed [SAMPLE_W-1:0]         want_r;
	} plan_row_t;

	// directed rows: frames with a hand-worked result carry typed = 1
	localparam plan_row_t DIR_PLAN [PLAN_ROWS] = '{
		// after reset: delayed sample is zero, output is half the input rounded up
		'{ROW_FRAME, sfd_pkg::REG_FEEDBACK_GAIN, 17'h0, 16'sh7FFF, 16'sh8000,
			1'b1, 16'sh4000, 16'shC000},
		'{ROW_FRAME, sfd_pkg::REG_FEEDBACK_GAIN, 17'h0, 16'sh0000, 16'shFFFF,
			1'b1, 16'sh0000, 16'sh0000},
		'{ROW_FRAME, sfd_pkg::REG_FEEDBACK_GAIN, 17'h0, 16'sh0001, 16'sh0001,
			1'b1, 16'sh0001, 16'sh0001},
		'{ROW_FRAME, sfd_pkg::REG_FEEDBACK_GAIN, 17'h0, 16'sh8000, 16'sh7FFF,
			1'b1, 16'shC000, 16'sh4000},
		// zero delay acts as one frame, fully wet, maximum feedback
		'{ROW_CFG, sfd_pkg::REG_DELAY_LEFT, 17'h00000, 16'sh0, 16'sh0,
			1'b0, 16'sh0, 16'sh0},
		'{ROW_CFG, sfd_pkg::REG_DELAY_RIGHT, 17'h00001, 16'sh0, 16'sh0,
			1'b0, 16'sh0, 16'sh0},
		'{ROW_CFG, sfd_pkg::REG_MIX_GAIN, 17'h00000, 16'sh0, 16'sh0,
			1'b0, 16'sh0, 16'sh0},
		'{ROW_CFG, sfd_pkg::REG_FEEDBACK_GAIN, 17'h0FFFF, 16'sh0, 16'sh0,
			1'b0, 16'sh0, 16'sh0},
		// wet output is exactly the previous frame's input
		'{ROW_FRAME, sfd_pkg::REG_FEEDBACK_GAIN, 17'h0, 16'sh3039, 16'shCFC7,
			1'b1, 16'sh8000, 16'sh7FFF},
		// feedback pushes the history into saturation
		'{ROW_FRAME, sfd_pkg::REG_FEEDBACK_GAIN, 17'h0, 16'sh7FFF, 16'sh7FFF,
			1'b0, 16'sh0, 16'sh0},
		'{ROW_FRAME, sfd_pkg::REG_FEEDBACK_GAIN, 17'h0, 16'sh7FFF, 16'sh7FFF,
			1'b0, 16'sh0, 16'sh0},
		'{ROW_FRAME, sfd_pkg::REG_FEEDBACK_GAIN, 17'h0, 16'sh7FFF, 16'sh8000,
			1'b0, 16'sh0, 16'sh0},
		'{ROW_FRAME, sfd_pkg::REG_FEEDBACK_GAIN, 17'h0, 16'sh8000, 16'sh8000,
			1'b0, 16'sh0, 16'sh0},
		// bit 16 of the write data is dropped for the gains
		'{ROW_CFG, sfd_pkg::REG_MIX_GAIN, 17'h1FFFF, 16'sh0, 16'sh0,
			1'b0, 16'sh0, 16'sh0},
		'{ROW_CFG, sfd_pkg::REG_FEEDBACK_GAIN, 17'h10000, 16'sh0, 16'sh0,
			1'b0, 16'sh0, 16'sh0},
		'{ROW_FRAME, sfd_pkg::REG_FEEDBACK_GAIN, 17'h0, 16'sh8000, 16'sh7FFF,
			1'b0, 16'sh0, 16'sh0},
		'{ROW_FRAME, sfd_pkg::REG_FEEDBACK_GAIN, 17'h0, 16'sh1234, 16'shEDCC,
			1'b0, 16'sh0, 16'sh0},
		// longest delay reads a slot never written since reset
		'{ROW_CFG, sfd_pkg::REG_MIX_GAIN, 17'h00000, 16'sh0, 16'sh0,
			1'b0, 16'sh0, 16'sh0},
		'{ROW_CFG, sfd_pkg::REG_DELAY_LEFT, 17'h1FFFF, 16'sh0, 16'sh0,
			1'b0, 16'sh0, 16'sh0},
		'{ROW_CFG, sfd_pkg::REG_DELAY_RIGHT, 17'h1FFFF, 16'sh0, 16'sh0,
			1'b0, 16'sh0, 16'sh0},
		'{ROW_FRAME, sfd_pkg::REG_FEEDBACK_GAIN, 17'h0, 16'sh5555, 16'shAAAA,
			1'b1, 16'sh0000, 16'sh0000},
		// back to a short delay and an even blend
		'{ROW_CFG, sfd_pkg::REG_DELAY_LEFT, 17'h00002, 16'sh0, 16'sh0,
			1'b0, 16'sh0, 16'sh0},
		'{ROW_CFG, sfd_pkg::REG_MIX_GAIN, 17'h08000, 16'sh0, 16'sh0,
			1'b0, 16'sh0, 16'sh0},
		'{ROW_FRAME, sfd_pkg::REG_FEEDBACK_GAIN, 17'h0, 16'sh4321, 16'sh8765,
			1'b0, 16'sh0, 16'sh0}
	};

	// block ports
	logic                                 clk       = 1'b0;
	logic                                 arst_n    = 1'b0;
	logic                                 cfg_wen   = 1'b0;
	logic [sfd_pkg::CFG_INDEX_BITS-1:0]   cfg_index = '0;
	logic [sfd_pkg::DELAY_BITS-1:0]       cfg_wdata = '0;
	logic                                 in_valid  = 1'b0;
	logic                                 in_ready;
	logic signed [SAMPLE_W-1:0]           in_left   = '0;
	logic signed [SAMPLE_W-1:0]           in_right  = '0;
	logic                                 out_valid;
	logic                                 out_ready = 1'b0;
	logic signed [SAMPLE_W-1:0]           out_left;
	logic signed [SAMPLE_W-1:0]           out_right;

	// predictor state
	logic signed [SAMPLE_W-1:0]       left_hist  [HIST_DEPTH];
	logic signed [SAMPLE_W-1:0]       right_hist [HIST_DEPTH];
	logic [sfd_pkg::GAIN_BITS-1:0]    feedback_now;
	logic [sfd_pkg::GAIN_BITS-1:0]    mix_now;
	logic [sfd_pkg::DELAY_BITS-1:0]   left_delay_now;
	logic [sfd_pkg::DELAY_BITS-1:0]   right_delay_now;
	int                               wr_slot;

	// expected output frames, oldest first
	frame_t out_frames_due [$];

	// hand-worked result travelling with the frame on the input
	logic   typed_due   = 1'b0;
	frame_t typed_frame = '0;

	rx_mode_t rx_mode    = RX_BURSTY;
	int       stall_left = 0;
	int       fail_count = 0;
	int       cycles     = 0;

	stereo_feedback_delay #(
		.HISTORY_DEPTH(HIST_DEPTH),
		.SAMPLE_BITS  (SAMPLE_W)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_left  (in_left),
		.in_right (in_right),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_left (out_left),
		.out_right(out_right)
	);

	// clock
	always #6 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// q0.16 product back to sample scale, rounding half up
	function automatic longint q16_round(input longint acc);
		return (acc + sfd_pkg::ROUND_HALF) >>> 16;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] clip(input longint v);
		if (v > SAMPLE_MAX)
			return SAMPLE_W'(SAMPLE_MAX);
		if (v < SAMPLE_MIN)
			return SAMPLE_W'(SAMPLE_MIN);
		return SAMPLE_W'(v);
	endfunction

	// history slot holding the sample written d frames ago
	function automatic int read_slot(input logic [sfd_pkg::DELAY_BITS-1:0] dly);
		int d;
		d = (dly == '0) ? 1 : int'(dly);
		if (d > HIST_DEPTH)
			d = HIST_DEPTH;
		return (wr_slot + HIST_DEPTH - d) % HIST_DEPTH;
	endfunction

	// wet and dry blend for the output
	function automatic logic signed [SAMPLE_W-1:0] blend_out(
		input logic signed [SAMPLE_W-1:0] y,
		input logic signed [SAMPLE_W-1:0] x
	);
		longint acc;
		acc = longint'(y) * (longint'(sfd_pkg::UNITY_GAIN) - longint'(mix_now))
			+ longint'(x) * longint'(mix_now);
		return clip(q16_round(acc));
	endfunction

	// input plus scaled echo, written back into the history
	function automatic logic signed [SAMPLE_W-1:0] echo_back(
		input logic signed [SAMPLE_W-1:0] y,
		input logic signed [SAMPLE_W-1:0] x
	);
		return clip(longint'(x) + q16_round(longint'(y) * longint'(feedback_now)));
	endfunction

	task automatic check_field(input string tag, input logic signed [SAMPLE_W-1:0] want,
			input logic signed [SAMPLE_W-1:0] got);
		if (got !== want) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, tag, want, got);
		end
	endtask

	// register writes, accepted frames and output transactions, sampled at the rising edge
	always @(posedge clk) begin
		frame_t                     want;
		logic signed [SAMPLE_W-1:0] yl;
		logic signed [SAMPLE_W-1:0] yr;
		if (arst_n) begin
			if (cfg_wen) begin
				case (sfd_pkg::cfg_reg_t'(cfg_index))
					sfd_pkg::REG_FEEDBACK_GAIN:
						feedback_now = cfg_wdata[sfd_pkg::GAIN_BITS-1:0];
					sfd_pkg::REG_MIX_GAIN:
						mix_now = cfg_wdata[sfd_pkg::GAIN_BITS-1:0];
					sfd_pkg::REG_DELAY_LEFT:
						left_delay_now = cfg_wdata;
					sfd_pkg::REG_DELAY_RIGHT:
						right_delay_now = cfg_wdata;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				yl = left_hist[read_slot(left_delay_now)];
				yr = right_hist[read_slot(right_delay_now)];
				want.left  = blend_out(yl, in_left);
				want.right = blend_out(yr, in_right);
				left_hist[wr_slot]  = echo_back(yl, in_left);
				right_hist[wr_slot] = echo_back(yr, in_right);
				wr_slot = (wr_slot + 1) % HIST_DEPTH;
				out_frames_due.push_back(typed_due ? typed_frame : want);
			end
			if (out_valid && out_ready) begin
				if (out_frames_due.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected output, expected none actual %0d %0d",
						$time, out_left, out_right);
				end else begin
					want = out_frames_due.pop_front();
					check_field("out_left", want.left, out_left);
					check_field("out_right", want.right, out_right);
				end
			end
		end
	end

	// receiver stalls
	always @(negedge clk) begin
		case (rx_mode)
			RX_OPEN: out_ready = 1'b1;
			RX_SPARSE: out_ready = ($urandom_range(0, 3) == 0);
			default: begin
				if (stall_left != 0) begin
					stall_left--;
					out_ready = 1'b0;
				end else if ($urandom_range(0, 5) == 0) begin
					stall_left = $urandom_range(0, 6);
					out_ready = 1'b0;
				end else begin
					out_ready = 1'b1;
				end
			end
		endcase
	end

	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return SAMPLE_W'(int'($urandom_range(0, 64)) - 32);
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	// gains include values with bit 16 set, which the block drops
	function automatic logic [sfd_pkg::DELAY_BITS-1:0] pick_gain();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return 17'h0FFFF;
			2: return 17'h08000;
			3: return 17'h00001;
			4: return sfd_pkg::DELAY_BITS'($urandom);
			default: return sfd_pkg::DELAY_BITS'($urandom_range(0, 65535));
		endcase
	endfunction

	// delays mostly short so echoes come back within a phase
	function automatic logic [sfd_pkg::DELAY_BITS-1:0] pick_delay();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return 17'h00001;
			2: return 17'h1FFFF;
			3: return sfd_pkg::DELAY_BITS'($urandom_range(49, 4000));
			4: return sfd_pkg::DELAY_BITS'($urandom);
			default: return sfd_pkg::DELAY_BITS'($urandom_range(1, 48));
		endcase
	endfunction

	// one input transaction, valid held until accepted
	task automatic send_frame(input logic signed [SAMPLE_W-1:0] l,
			input logic signed [SAMPLE_W-1:0] r, input logic typed, input frame_t want);
		@(negedge clk);
		in_valid    = 1'b1;
		in_left     = l;
		in_right    = r;
		typed_due   = typed;
		typed_frame = want;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic idle_gap(input int n);
		@(negedge clk);
		in_valid = 1'b0;
		in_left  = SAMPLE_W'($urandom);
		in_right = SAMPLE_W'($urandom);
		repeat (n - 1) @(negedge clk);
	endtask

	// hold off until every expected frame has come out
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (out_frames_due.size() != 0) @(negedge clk);
	endtask

	task automatic write_reg(input sfd_pkg::cfg_reg_t idx,
			input logic [sfd_pkg::DELAY_BITS-1:0] value);
		@(negedge clk);
		cfg_wen   = 1'b1;
		cfg_index = idx;
		cfg_wdata = value;
		@(negedge clk);
		cfg_wen   = 1'b0;
	endtask

	// stimulus
	initial begin
		int n;
		int burst_left;
		bit gappy;

		// predictor reset state
		foreach (left_hist[i]) begin
			left_hist[i]  = '0;
			right_hist[i] = '0;
		end
		feedback_now    = 16'd32768;
		mix_now         = 16'd32768;
		left_delay_now  = 17'd24000;
		right_delay_now = 17'd24000;
		wr_slot         = 0;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed rows
		for (int k = 0; k < PLAN_ROWS; k++) begin
			if (DIR_PLAN[k].kind == ROW_CFG) begin
				drain();
				write_reg(DIR_PLAN[k].reg_idx, DIR_PLAN[k].value);
			end else begin
				send_frame(DIR_PLAN[k].stim_l, DIR_PLAN[k].stim_r, DIR_PLAN[k].typed,
					frame_t'{DIR_PLAN[k].want_l, DIR_PLAN[k].want_r});
				if ($urandom_range(0, 2) == 0)
					idle_gap($urandom_range(1, 3));
			end
		end

		// random phases, each with a random choice of register writes and receiver behavior
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			drain();
			if ($urandom_range(0, 1))
				write_reg(sfd_pkg::REG_FEEDBACK_GAIN, pick_gain());
			if ($urandom_range(0, 1))
				write_reg(sfd_pkg::REG_MIX_GAIN, pick_gain());
			if ($urandom_range(0, 1))
				write_reg(sfd_pkg::REG_DELAY_LEFT, pick_delay());
			if ($urandom_range(0, 1))
				write_reg(sfd_pkg::REG_DELAY_RIGHT, pick_delay());
			rx_mode    = rx_mode_t'($urandom_range(0, 2));
			gappy      = ($urandom_range(0, 3) != 0);
			burst_left = $urandom_range(1, 16);
			n          = $urandom_range(45, 75);
			repeat (n) begin
				send_frame(pick_sample(), pick_sample(), 1'b0, '0);
				if ($urandom_range(0, 59) == 0) begin
					drain();
				end else if (gappy) begin
					burst_left--;
					if (burst_left == 0) begin
						idle_gap($urandom_range(1, 6));
						burst_left = $urandom_range(1, 16);
					end
				end
			end
		end

		// wind down
		drain();
		repeat (6) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/sfd_pkg.sv
rtl/sfd_channel.sv
rtl/stereo_feedback_delay.sv
test/tb_stereo_feedback_delay.sv
